[rtl/core/cab_pkg.sv]
// Types, codes and defaults shared by the alpha blitter modules.
package cab_pkg;

	localparam int MAX_FRAME_WIDTH_DEF  = 256;
	localparam int MAX_FRAME_HEIGHT_DEF = 256;

	// Read words in flight plus waiting words never exceed this.
	localparam int OUT_FIFO_DEPTH = 8;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 11;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DEST_X       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DEST_Y       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT   = 3'd5;

	localparam logic [1:0] KIND_PIXEL = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;
	localparam logic [1:0] KIND_START = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [15:0] address;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
	} out_word_t;

	// Frame word layout: red in the low byte, alpha in the high byte.
	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_BLEND,
		OP_WRITE,
		OP_READ
	} op_t;

	// Operation handed to the frame store; blank forces a read to return zero.
	typedef struct packed {
		op_t    op;
		logic   blank;
		pixel_t pix;
	} store_ctl_t;

endpackage

[rtl/core/cab_store.sv]
// Frame store memory with read-modify-write blending and write forwarding.
module cab_store
	import cab_pkg::*;
#(
	parameter int DEPTH = MAX_FRAME_WIDTH_DEF * MAX_FRAME_HEIGHT_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  store_ctl_t    ctl,
	input  logic [AW-1:0] addr,
	output logic          rd_valid,
	output pixel_t        rd_data
);

	pixel_t        mem [DEPTH];
	pixel_t        rdata_q;
	store_ctl_t    ctl_s3;
	logic [AW-1:0] addr_s3;
	logic          wb_valid_q;
	logic [AW-1:0] wb_addr_q;
	pixel_t        wb_data_q;
	pixel_t        cur;
	pixel_t        blended;
	pixel_t        wdata;
	logic          we;
	logic [7:0]    inv_a;
	logic [8:0]    alpha_sum;

	function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] d,
		input logic [7:0] a, input logic [7:0] ia);
		logic [15:0] acc;
		acc = 16'(s * a) + 16'(d * ia);
		return acc[15:8];
	endfunction

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr_s3] <= wdata;
		end
		rdata_q <= mem[addr];
		addr_s3 <= addr;
		wb_addr_q <= addr_s3;
		wb_data_q <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3     <= '{op: OP_NONE, blank: 1'b0, pix: '0};
			wb_valid_q <= 1'b0;
		end else begin
			ctl_s3     <= ctl;
			wb_valid_q <= we;
		end
	end

	// The word written in the previous cycle is not yet seen by the memory read.
	assign cur = (wb_valid_q && wb_addr_q == addr_s3) ? wb_data_q : rdata_q;

	assign inv_a     = 8'd255 - ctl_s3.pix.alpha;
	assign alpha_sum = {1'b0, cur.alpha} + {1'b0, ctl_s3.pix.alpha};

	always_comb begin
		blended.red   = mix(ctl_s3.pix.red,   cur.red,   ctl_s3.pix.alpha, inv_a);
		blended.green = mix(ctl_s3.pix.green, cur.green, ctl_s3.pix.alpha, inv_a);
		blended.blue  = mix(ctl_s3.pix.blue,  cur.blue,  ctl_s3.pix.alpha, inv_a);
		blended.alpha = alpha_sum[8] ? 8'd255 : alpha_sum[7:0];
	end

	assign we       = (ctl_s3.op == OP_BLEND) || (ctl_s3.op == OP_WRITE);
	assign wdata    = (ctl_s3.op == OP_WRITE) ? ctl_s3.pix : blended;
	assign rd_valid = (ctl_s3.op == OP_READ);
	assign rd_data  = ctl_s3.blank ? pixel_t'('0) : cur;

	write_then_forward: assert property (@(posedge clk) disable iff (!arst_n)
		we |=> wb_valid_q && wb_addr_q == $past(addr_s3))
		else $error("write-back register missed a store write");

	read_not_write: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid |-> !we)
		else $error("read and write issued by one word");

	blank_only_reads: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s3.blank |-> rd_valid)
		else $error("blank flag on a word that is not a read");

endmodule

[rtl/core/cab_out_fifo.sv]
// Result queue between the frame store and the output channel.
module cab_out_fifo
	import cab_pkg::*;
#(
	parameter int DEPTH = OUT_FIFO_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_word_t push_data,
	input  logic      pop,
	output logic      not_empty,
	output out_word_t head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	out_word_t       entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> 32'(count_q) < DEPTH)
		else $error("result queue overflow");

	no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("result queue underflow");

	count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a push");

endmodule

[rtl/core/clipped_alpha_blit.sv]
// Top level of the clipped alpha blitter: position tracking, clipping, addressing.
//
//  channel | direction | handshake             | word
//  in      | input     | in_valid / in_stall   | in_word_t: kind, rgba, address
//  out     | output    | out_valid / out_stall | out_word_t: rgba of a frame word read
//  cfg     | input     | cfg_we                | cfg_index, cfg_data (11 bits)
//
// One word is taken every cycle while in_stall is low; read results queue for out_valid.
// The memory read of stage 2 and the blend and write of stage 3 overlap for back-to-back
// words; a word that touches the address its predecessor writes takes it by forwarding.
// in_stall rises only when 8 read results are reserved (queued or in flight).
// Reset clears position and pipeline and sets register defaults; memory is not cleared.
module clipped_alpha_blit
	import cab_pkg::*;
#(
	parameter int MAX_FRAME_WIDTH  = MAX_FRAME_WIDTH_DEF,
	parameter int MAX_FRAME_HEIGHT = MAX_FRAME_HEIGHT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_word_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_word_t              out_data,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int DEPTH = MAX_FRAME_WIDTH * MAX_FRAME_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(OUT_FIFO_DEPTH + 1);

	logic [8:0]         frame_width_q;
	logic [8:0]         frame_height_q;
	logic signed [10:0] dest_x_q;
	logic signed [10:0] dest_y_q;
	logic [9:0]         src_width_q;
	logic [9:0]         src_height_q;
	logic [9:0]         src_col_q;
	logic [9:0]         src_row_q;
	logic [RW-1:0]      credit_q;

	logic               accept;
	logic               pop;
	logic [8:0]         fw;
	logic [8:0]         fh;
	logic [9:0]         sw;
	logic [9:0]         sh;
	logic signed [11:0] col_s0;
	logic signed [11:0] row_s0;
	logic               in_frame;
	logic               in_range;
	store_ctl_t         ctl_s0;

	store_ctl_t         ctl_s1;
	logic [8:0]         col_s1;
	logic [8:0]         row_s1;
	logic [AW-1:0]      addr_s1;
	store_ctl_t         ctl_s2;
	logic [AW-1:0]      addr_s2;
	logic [17:0]        pix_index;

	logic               rd_valid;
	pixel_t             rd_data;
	out_word_t          rd_word;

	assign accept = in_valid && !in_stall;
	assign pop    = out_valid && !out_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 9'd256;
			frame_height_q <= 9'd256;
			dest_x_q       <= '0;
			dest_y_q       <= '0;
			src_width_q    <= 10'd1;
			src_height_q   <= 10'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[8:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[8:0];
				REG_DEST_X:       dest_x_q       <= signed'(cfg_data);
				REG_DEST_Y:       dest_y_q       <= signed'(cfg_data);
				REG_SRC_WIDTH:    src_width_q    <= cfg_data[9:0];
				REG_SRC_HEIGHT:   src_height_q   <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign fw = (32'(frame_width_q) > MAX_FRAME_WIDTH) ? 9'(MAX_FRAME_WIDTH) : frame_width_q;
	assign fh = (32'(frame_height_q) > MAX_FRAME_HEIGHT) ?
		9'(MAX_FRAME_HEIGHT) : frame_height_q;
	assign sw = (src_width_q == '0) ? 10'd1 : src_width_q;
	assign sh = (src_height_q == '0) ? 10'd1 : src_height_q;

	// Source position; every source pixel advances it, clipped or not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
		end else if (accept) begin
			if (in_data.kind == KIND_START) begin
				src_col_q <= '0;
				src_row_q <= '0;
			end else if (in_data.kind == KIND_PIXEL) begin
				if ({1'b0, src_col_q} + 11'd1 >= {1'b0, sw}) begin
					src_col_q <= '0;
					if ({1'b0, src_row_q} + 11'd1 >= {1'b0, sh}) begin
						src_row_q <= '0;
					end else begin
						src_row_q <= src_row_q + 10'd1;
					end
				end else begin
					src_col_q <= src_col_q + 10'd1;
				end
			end
		end
	end

	assign col_s0 = 12'(dest_x_q) + signed'({2'b00, src_col_q});
	assign row_s0 = 12'(dest_y_q) + signed'({2'b00, src_row_q});

	assign in_frame = !col_s0[11] && !row_s0[11] &&
		(col_s0[10:0] < {2'b00, fw}) && (row_s0[10:0] < {2'b00, fh});
	assign in_range = 32'(in_data.address) < DEPTH;

	always_comb begin
		ctl_s0.op    = OP_NONE;
		ctl_s0.blank = 1'b0;
		ctl_s0.pix   = '{alpha: in_data.alpha, blue: in_data.blue,
			green: in_data.green, red: in_data.red};
		if (accept) begin
			unique case (in_data.kind)
				KIND_PIXEL: begin
					if (in_frame && in_data.alpha != 8'd0) begin
						ctl_s0.op = OP_BLEND;
					end
				end
				KIND_WRITE: begin
					if (in_range) begin
						ctl_s0.op = OP_WRITE;
					end
				end
				KIND_READ: begin
					ctl_s0.op    = OP_READ;
					ctl_s0.blank = !in_range;
				end
				default: ;
			endcase
		end
	end

	// Stage 1 holds the clipped frame position; stage 2 holds the memory address.
	always_ff @(posedge clk) begin
		col_s1  <= col_s0[8:0];
		row_s1  <= row_s0[8:0];
		addr_s1 <= AW'(in_data.address);
		addr_s2 <= (ctl_s1.op == OP_BLEND) ? AW'(pix_index) : addr_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '{op: OP_NONE, blank: 1'b0, pix: '0};
			ctl_s2 <= '{op: OP_NONE, blank: 1'b0, pix: '0};
		end else begin
			ctl_s1 <= ctl_s0;
			ctl_s2 <= ctl_s1;
		end
	end

	assign pix_index = 18'(row_s1 * fw) + {9'd0, col_s1};

	cab_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_s2),
		.addr     (addr_s2),
		.rd_valid (rd_valid),
		.rd_data  (rd_data)
	);

	assign rd_word = '{out_red: rd_data.red, out_green: rd_data.green,
		out_blue: rd_data.blue, out_alpha: rd_data.alpha};

	cab_out_fifo #(
		.DEPTH (OUT_FIFO_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rd_valid),
		.push_data (rd_word),
		.pop       (pop),
		.not_empty (out_valid),
		.head      (out_data)
	);

	// A queue slot is reserved when a read word is taken and freed when its result leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + RW'(accept && in_data.kind == KIND_READ) - RW'(pop);
		end
	end

	assign in_stall = (32'(credit_q) >= OUT_FIFO_DEPTH);

	credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(credit_q) <= OUT_FIFO_DEPTH)
		else $error("reserved result slots exceed the queue depth");

	result_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> credit_q != '0)
		else $error("result present without a reserved slot");

	read_reaches_store: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_data.kind == KIND_READ |-> ##3 rd_valid)
		else $error("read word did not reach the frame store in time");

	blend_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.op == OP_BLEND |-> col_s1 < fw && row_s1 < fh)
		else $error("blend position outside the frame");

endmodule

[bench/tb_clipped_alpha_blit.sv]
// Self-checking testbench for the clipped alpha blitter: random traffic against a frame-image model.
`timescale 1ns / 1ps

module tb_clipped_alpha_blit;
	import cab_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TARGET_WORDS = 1150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	clipped_alpha_blit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Register shadow, shared by the stimulus side and the frame model.
	logic [8:0] frame_w = 9'd256;
	logic [8:0] frame_h = 9'd256;
	logic signed [10:0] dest_x = '0;
	logic signed [10:0] dest_y = '0;
	logic [9:0] src_w = 10'd1;
	logic [9:0] src_h = 10'd1;

	// Frame model, advanced on every accepted input word.
	pixel_t frame_img [0:65535];
	logic [9:0] blit_col = '0;
	logic [9:0] blit_row = '0;
	out_word_t reads_due[$];

	// Stimulus side: its own source position and the set of frame words written so far.
	in_word_t pending[$];
	logic [9:0] feed_col = '0;
	logic [9:0] feed_row = '0;
	bit seen_written [0:65535];
	int written_q[$];
	int recent_q[$];

	int words_sent = 0;
	int words_taken = 0;
	int fail_count = 0;
	int cycles = 0;
	bit in_taken = 1'b0;
	bit quiet = 1'b0;
	int send_gap = 0;
	int hold_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Frame word index of a source position, or -1 when the pixel is clipped.
	function automatic int target_index(logic [9:0] col, logic [9:0] row);
		int fw, fh, x, y;
		fw = (int'(frame_w) > MAX_FRAME_WIDTH_DEF) ? MAX_FRAME_WIDTH_DEF : int'(frame_w);
		fh = (int'(frame_h) > MAX_FRAME_HEIGHT_DEF) ? MAX_FRAME_HEIGHT_DEF : int'(frame_h);
		x = int'(dest_x) + int'(col);
		y = int'(dest_y) + int'(row);
		if (x < 0 || y < 0 || x >= fw || y >= fh)
			return -1;
		return y * fw + x;
	endfunction

	// Raster advance; a position already past a shrunk size wraps like the last one.
	function automatic logic [19:0] next_position(logic [9:0] col, logic [9:0] row);
		int w, h;
		w = (src_w == 0) ? 1 : int'(src_w);
		h = (src_h == 0) ? 1 : int'(src_h);
		if (int'(col) + 1 >= w) begin
			col = '0;
			if (int'(row) + 1 >= h)
				row = '0;
			else
				row = row + 10'd1;
		end else begin
			col = col + 10'd1;
		end
		return {row, col};
	endfunction

	function automatic logic [7:0] mix_channel(logic [7:0] s, logic [7:0] d, logic [7:0] a);
		int acc;
		acc = int'(s) * int'(a) + int'(d) * (255 - int'(a));
		return 8'(acc >> 8);
	endfunction

	function automatic logic [7:0] chan_value();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t p;
		p.red = chan_value();
		p.green = chan_value();
		p.blue = chan_value();
		p.alpha = chan_value();
		return p;
	endfunction

	task automatic update_frame_image(in_word_t w);
		int idx, sum;
		pixel_t old, upd;
		out_word_t rd;
		case (w.kind)
			KIND_PIXEL: begin
				idx = target_index(blit_col, blit_row);
				if (idx >= 0 && w.alpha != 8'd0) begin
					old = frame_img[idx];
					sum = int'(old.alpha) + int'(w.alpha);
					upd.red = mix_channel(w.red, old.red, w.alpha);
					upd.green = mix_channel(w.green, old.green, w.alpha);
					upd.blue = mix_channel(w.blue, old.blue, w.alpha);
					upd.alpha = (sum > 255) ? 8'hff : 8'(sum);
					frame_img[idx] = upd;
				end
				{blit_row, blit_col} = next_position(blit_col, blit_row);
			end
			KIND_WRITE: begin
				upd.red = w.red;
				upd.green = w.green;
				upd.blue = w.blue;
				upd.alpha = w.alpha;
				frame_img[w.address] = upd;
			end
			KIND_READ: begin
				old = frame_img[w.address];
				rd.out_red = old.red;
				rd.out_green = old.green;
				rd.out_blue = old.blue;
				rd.out_alpha = old.alpha;
				reads_due.push_back(rd);
			end
			default: begin
				blit_col = '0;
				blit_row = '0;
			end
		endcase
	endtask

	always @(posedge clk) begin : monitor
		out_word_t want;
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (reads_due.size() == 0) begin
					$error("read word arrived with nothing expected");
					fail_count++;
				end else begin
					want = reads_due.pop_front();
					if (out_data.out_red !== want.out_red) begin
						$error("out_red: expected %0d, got %0d", want.out_red, out_data.out_red);
						fail_count++;
					end
					if (out_data.out_green !== want.out_green) begin
						$error("out_green: expected %0d, got %0d", want.out_green,
							out_data.out_green);
						fail_count++;
					end
					if (out_data.out_blue !== want.out_blue) begin
						$error("out_blue: expected %0d, got %0d", want.out_blue, out_data.out_blue);
						fail_count++;
					end
					if (out_data.out_alpha !== want.out_alpha) begin
						$error("out_alpha: expected %0d, got %0d", want.out_alpha,
							out_data.out_alpha);
						fail_count++;
					end
				end
			end
			in_taken = in_valid && !in_stall;
			if (in_taken) begin
				update_frame_image(in_data);
				words_taken++;
			end
		end
	end

	// Sender: a new word only once the current one is taken; random gaps in between.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (send_gap == 0 && !quiet && $urandom_range(0, 7) == 0)
				send_gap = $urandom_range(1, 9);
			if (send_gap > 0 || pending.size() == 0) begin
				if (send_gap > 0)
					send_gap--;
				in_valid <= 1'b0;
			end else begin
				in_data <= pending.pop_front();
				in_valid <= 1'b1;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left == 0 && !quiet && $urandom_range(0, 7) == 0)
				hold_left = $urandom_range(1, 9);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic mark_written(int idx);
		if (!seen_written[idx]) begin
			seen_written[idx] = 1'b1;
			written_q.push_back(idx);
		end
	endtask

	task automatic queue_word(logic [1:0] kind, pixel_t p, logic [15:0] addr);
		in_word_t w;
		int idx;
		w.kind = kind;
		w.red = p.red;
		w.green = p.green;
		w.blue = p.blue;
		w.alpha = p.alpha;
		w.address = addr;
		case (kind)
			KIND_PIXEL: begin
				idx = target_index(feed_col, feed_row);
				if (idx >= 0) begin
					recent_q.push_back(idx);
					if (recent_q.size() > 32)
						void'(recent_q.pop_front());
				end
				{feed_row, feed_col} = next_position(feed_col, feed_row);
			end
			KIND_WRITE: mark_written(int'(addr));
			KIND_START: begin
				feed_col = '0;
				feed_row = '0;
			end
			default: ;
		endcase
		pending.push_back(w);
		words_sent++;
	endtask

	// A blend onto a word never written is not allowed, so such a target is loaded first.
	// Sometimes the target is reloaded anyway, which puts a write right before its blend.
	task automatic queue_pixel(pixel_t p);
		int idx;
		idx = target_index(feed_col, feed_row);
		if (idx >= 0 && p.alpha != 8'd0 && (!seen_written[idx] || $urandom_range(0, 7) == 0))
			queue_word(KIND_WRITE, rand_pixel(), 16'(idx));
		queue_word(KIND_PIXEL, p, 16'($urandom));
	endtask

	task automatic queue_read();
		int idx;
		idx = -1;
		if (recent_q.size() != 0 && $urandom_range(0, 1) == 1)
			idx = recent_q[$urandom_range(0, recent_q.size() - 1)];
		if (idx < 0 || !seen_written[idx]) begin
			if (written_q.size() == 0)
				return;
			idx = written_q[$urandom_range(0, written_q.size() - 1)];
		end
		queue_word(KIND_READ, rand_pixel(), 16'(idx));
	endtask

	function automatic logic [15:0] rand_addr();
		if ($urandom_range(0, 1) == 1)
			return 16'($urandom);
		return 16'($urandom_range(0, 511));
	endfunction

	// Waits until every word is taken and every read has returned, then lets the pipe empty.
	task automatic drain();
		while (words_taken != words_sent || reads_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] index, int value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value[CFG_DATA_W-1:0];
		case (index)
			REG_FRAME_WIDTH: frame_w = value[8:0];
			REG_FRAME_HEIGHT: frame_h = value[8:0];
			REG_DEST_X: dest_x = value[10:0];
			REG_DEST_Y: dest_y = value[10:0];
			REG_SRC_WIDTH: src_w = value[9:0];
			default: src_h = value[9:0];
		endcase
		@(negedge clk);
	endtask

	task automatic pick_setup(bit all_regs);
		int fw, fh, dx, dy, sw, sh, shape;
		shape = $urandom_range(0, 13);
		fw = $urandom_range(1, 12);
		fh = $urandom_range(1, 8);
		dx = $urandom_range(0, 16) - 6;
		dy = $urandom_range(0, 10) - 4;
		sw = $urandom_range(1, 10);
		sh = $urandom_range(1, 6);
		case (shape)
			0: fw = 0;
			1: fh = 0;
			2: begin
				// Oversized frame registers saturate to the store size.
				fw = $urandom_range(257, 511);
				fh = $urandom_range(257, 511);
				dx = $urandom_range(248, 254);
				dy = $urandom_range(250, 255);
			end
			3: begin
				dx = -1024;
				dy = -1024;
				sw = 1023;
				sh = 1023;
			end
			4: begin
				dx = 1023;
				dy = 1023;
			end
			5: begin
				sw = 0;
				sh = 0;
			end
			6: begin
				fw = 256;
				fh = 256;
				dx = $urandom_range(253, 255);
				dy = $urandom_range(253, 255);
			end
			7: begin
				fw = 1;
				fh = 1;
			end
			8: begin
				fw = $urandom_range(0, 511);
				fh = $urandom_range(0, 511);
				dx = $urandom_range(0, 2047) - 1024;
				dy = $urandom_range(0, 2047) - 1024;
				sw = $urandom_range(0, 1023);
				sh = $urandom_range(0, 1023);
			end
			default: ;
		endcase
		if (shape <= 8)
			all_regs = 1'b1;
		if (all_regs || $urandom_range(0, 3) != 0)
			write_reg(REG_FRAME_WIDTH, fw);
		if (all_regs || $urandom_range(0, 3) != 0)
			write_reg(REG_FRAME_HEIGHT, fh);
		if (all_regs || $urandom_range(0, 3) != 0)
			write_reg(REG_DEST_X, dx);
		if (all_regs || $urandom_range(0, 3) != 0)
			write_reg(REG_DEST_Y, dy);
		if (all_regs || $urandom_range(0, 3) != 0)
			write_reg(REG_SRC_WIDTH, sw);
		if (all_regs || $urandom_range(0, 3) != 0)
			write_reg(REG_SRC_HEIGHT, sh);
		cfg_we <= 1'b0;
	endtask

	// One source image (or its start) in raster order, usually from a start word, with some reads
	// and writes mixed in; a short image may be streamed past its end so that the position wraps.
	task automatic blit_phase();
		int area, count;
		area = ((src_w == 0) ? 1 : int'(src_w)) * ((src_h == 0) ? 1 : int'(src_h));
		count = area;
		if (area <= 30)
			count = area * $urandom_range(1, 2) + $urandom_range(0, 2);
		if (count > 60)
			count = $urandom_range(20, 60);
		if ($urandom_range(0, 3) != 0)
			queue_word(KIND_START, rand_pixel(), 16'($urandom));
		repeat (count) begin
			queue_pixel(rand_pixel());
			case ($urandom_range(0, 15))
				0, 1: queue_read();
				2: queue_word(KIND_WRITE, rand_pixel(), rand_addr());
				default: ;
			endcase
		end
		repeat ($urandom_range(1, 12)) queue_read();
	endtask

	task automatic noise_phase();
		repeat ($urandom_range(10, 40)) begin
			case ($urandom_range(0, 9))
				5, 6: queue_read();
				7, 8: queue_word(KIND_WRITE, rand_pixel(), rand_addr());
				9: queue_word(KIND_START, rand_pixel(), 16'($urandom));
				default: queue_pixel(rand_pixel());
			endcase
		end
	endtask

	initial begin : stimulus
		bit first;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings put every source pixel on word 0.
		queue_word(KIND_WRITE, 32'h10_00_80_ff, 16'h0000);
		queue_word(KIND_WRITE, 32'hff_ff_ff_ff, 16'hffff);
		queue_word(KIND_WRITE, 32'h00_00_00_00, 16'h8000);
		queue_word(KIND_READ, 32'h00_00_00_00, 16'h0000);
		queue_word(KIND_READ, 32'hff_ff_ff_ff, 16'hffff);
		// Opaque pixel: alpha sum saturates at 255.
		queue_pixel(32'hff_80_ff_00);
		// Zero alpha leaves the word alone.
		queue_pixel(32'h00_ff_ff_ff);
		queue_pixel(32'h01_ff_00_ff);
		queue_word(KIND_READ, 32'h00_00_00_00, 16'h0000);
		// Blends straight after a write and after each other hit the same word.
		queue_word(KIND_WRITE, 32'h00_00_00_00, 16'h0000);
		queue_pixel(32'h80_ff_ff_ff);
		queue_pixel(32'hff_00_00_00);
		queue_word(KIND_START, 32'hff_ff_ff_ff, 16'hffff);
		queue_word(KIND_READ, 32'h00_00_00_00, 16'h0000);
		queue_word(KIND_READ, 32'h00_00_00_00, 16'h8000);
		drain();

		first = 1'b1;
		while (words_sent < TARGET_WORDS) begin
			quiet = (words_sent > TARGET_WORDS - 150) || ($urandom_range(0, 4) == 0);
			pick_setup(first);
			first = 1'b0;
			if ($urandom_range(0, 4) == 0)
				noise_phase();
			else
				blit_phase();
			drain();
		end

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[files.f]
rtl/core/cab_pkg.sv
rtl/core/cab_store.sv
rtl/core/cab_out_fifo.sv
rtl/core/clipped_alpha_blit.sv
bench/tb_clipped_alpha_blit.sv
